// File: rtl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg: shared definitions for the contactor feedback supervisor
// Field widths, state codes, action codes, fault codes and defaults.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int ActionW   = 3;
  localparam int FeedbackW = 2;
  localparam int StateW    = 3;
  localparam int FaultW    = 4;
  localparam int TimeoutW  = 16;

  localparam int TimerBitsDefault = 16;
  localparam logic [TimeoutW-1:0] StartTimeoutReset = 16'd1000;

  // Unit states.
  localparam logic [StateW-1:0] StNotInit  = 3'd0;
  localparam logic [StateW-1:0] StOff      = 3'd1;
  localparam logic [StateW-1:0] StStarting = 3'd2;
  localparam logic [StateW-1:0] StOn       = 3'd3;
  localparam logic [StateW-1:0] StStopping = 3'd4;
  localparam logic [StateW-1:0] StHalt     = 3'd5;
  localparam logic [StateW-1:0] StLost     = 3'd6;
  localparam logic [StateW-1:0] StError    = 3'd7;

  // Actions.
  localparam logic [ActionW-1:0] ActTick = 3'd0;
  localparam logic [ActionW-1:0] ActOn   = 3'd1;
  localparam logic [ActionW-1:0] ActOff  = 3'd2;
  localparam logic [ActionW-1:0] ActHalt = 3'd3;
  localparam logic [ActionW-1:0] ActInit = 3'd4;

  // Feedback levels.
  localparam logic [FeedbackW-1:0] FbOff = 2'd0;
  localparam logic [FeedbackW-1:0] FbOn  = 2'd1;

  // Fault codes.
  localparam logic [FaultW-1:0] FaultNone        = 4'd0;
  localparam logic [FaultW-1:0] FaultOffCoil     = 4'd1;
  localparam logic [FaultW-1:0] FaultOffContact  = 4'd2;
  localparam logic [FaultW-1:0] FaultStartCoil   = 4'd3;
  localparam logic [FaultW-1:0] FaultStartContact = 4'd4;
  localparam logic [FaultW-1:0] FaultStopCoil    = 4'd5;
  localparam logic [FaultW-1:0] FaultStopContact = 4'd6;
  localparam logic [FaultW-1:0] FaultOnCoil      = 4'd7;
  localparam logic [FaultW-1:0] FaultOnContact   = 4'd8;

endpackage

// File: rtl/contactor_feedback_supervisor_top.sv
// ----------------------------------------------------------------------------
// Contactor feedback supervisor
// Drives the contactor coil and checks coil read-back and auxiliary contact
// feedback against the unit state, one event request at a time.
// ----------------------------------------------------------------------------
// An accepted input request passes through the input register and then the
// result register. Throughput: one request per cycle while results are taken;
// the state update is a single pass through the decision logic and one
// saturating timer increment with its compare.
// Reset puts the unit in the not initialised state with the coil released,
// the start timer cleared and disarmed, and start_timeout at 1000 ticks.
module contactor_feedback_supervisor_top #(
  parameter int TIMER_BITS = cfs_pkg::TimerBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel (start_timeout).
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cfs_pkg::TimeoutW-1:0]  cfg_data_i,
  // Event request channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cfs_pkg::ActionW-1:0]   action_i,
  input  logic [cfs_pkg::FeedbackW-1:0] coil_feedback_i,
  input  logic [cfs_pkg::FeedbackW-1:0] contact_feedback_i,
  // Result request channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cfs_pkg::StateW-1:0]    unit_state_o,
  output logic                         coil_drive_o,
  output logic [cfs_pkg::FaultW-1:0]    fault_code_o,
  output logic                         rejected_o,
  output logic                         changed_o
);
  import cfs_pkg::*;

  // Width used to compare the timer against the 16-bit timeout register.
  localparam int CmpW = (TIMER_BITS > TimeoutW) ? TIMER_BITS : TimeoutW;

  // Configuration register. Writes only arrive while the block is idle: the user
  // must keep to this, the block does not enforce it. The decision logic uses it directly.
  logic [TimeoutW-1:0] start_timeout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_timeout_q <= StartTimeoutReset;
    end else if (cfg_valid_i) begin
      start_timeout_q <= cfg_data_i;
    end
  end

  // Input register stage.
  logic                 s1_valid_q;
  logic [ActionW-1:0]   act_q;
  logic [FeedbackW-1:0] coil_q;
  logic [FeedbackW-1:0] contact_q;
  logic                 advance;

  // The input stage moves on whenever the result register is free or is
  // being emptied in the same cycle, so requests flow back to back.
  assign advance    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      act_q     <= action_i;
      coil_q    <= coil_feedback_i;
      contact_q <= contact_feedback_i;
    end
  end

  // Unit state.
  logic [StateW-1:0]     state_q, state_d;
  logic                  drive_q, drive_d;
  logic [TIMER_BITS-1:0] ticks_q, ticks_d;
  logic                  armed_q, armed_d;

  logic [FaultW-1:0]     code;
  logic                  rej;
  logic                  do_eval;
  logic [StateW-1:0]     eval_st;
  logic [TIMER_BITS-1:0] ticks_inc;
  logic                  conn_fault;

  // Saturating increment of the start timer.
  assign ticks_inc  = (&ticks_q) ? ticks_q : ticks_q + TIMER_BITS'(1);
  // Feedback codes two and three both mean a broken connection.
  assign conn_fault = coil_q[1] || contact_q[1];

  always_comb begin
    state_d = state_q;
    drive_d = drive_q;
    ticks_d = ticks_q;
    armed_d = armed_q;
    code    = FaultNone;
    rej     = 1'b0;
    do_eval = 1'b0;
    eval_st = state_q;

    // Command decode. Init forces off and then checks the feedback as a tick.
    unique case (act_q)
      ActTick: begin
        do_eval = 1'b1;
      end
      ActOn: begin
        if (state_q == StOff) begin
          state_d = StStarting;
          drive_d = 1'b1;
          armed_d = 1'b0;
          ticks_d = '0;
        end else begin
          rej = 1'b1;
        end
      end
      ActOff: begin
        if (state_q == StOn || state_q == StStarting) begin
          state_d = StStopping;
          drive_d = 1'b0;
          armed_d = 1'b0;
          ticks_d = '0;
        end else begin
          rej = 1'b1;
        end
      end
      ActHalt: begin
        drive_d = 1'b0;
        state_d = StHalt;
      end
      ActInit: begin
        state_d = StOff;
        eval_st = StOff;
        do_eval = 1'b1;
      end
      default: begin
        // Unknown actions are ignored and not reported as refused.
      end
    endcase

    // Feedback evaluation against the state in force for this event.
    if (do_eval && eval_st != StNotInit) begin
      if (conn_fault) begin
        state_d = StLost;
      end else begin
        unique case (eval_st)
          StOff: begin
            // When both checks fail, the contact mismatch wins.
            if (contact_q != FbOff) begin
              code = FaultOffContact;
            end else if (coil_q != FbOff) begin
              code = FaultOffCoil;
            end
          end
          StOn: begin
            if (coil_q != FbOn) begin
              code = FaultOnCoil;
            end else if (contact_q != FbOn) begin
              code = FaultOnContact;
            end
          end
          StStarting: begin
            // The first tick arms the timer and energizes the coil; later
            // ticks count until the timeout is exceeded.
            if (!armed_q) begin
              drive_d = 1'b1;
              armed_d = 1'b1;
              ticks_d = '0;
            end else begin
              ticks_d = ticks_inc;
              if (CmpW'(ticks_inc) > CmpW'(start_timeout_q)) begin
                state_d = StOn;
              end
            end
            if (coil_q != FbOn) begin
              code = FaultStartCoil;
            end else if (contact_q != FbOn) begin
              code = FaultStartContact;
            end
          end
          StStopping: begin
            drive_d = 1'b0;
            state_d = StOff;
            if (coil_q != FbOff) begin
              code = FaultStopCoil;
            end else if (contact_q != FbOff) begin
              code = FaultStopContact;
            end
          end
          default: begin
            // Halt, lost connection and error only check the connection.
          end
        endcase
        if (code != FaultNone) begin
          state_d = StError;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StNotInit;
      drive_q <= 1'b0;
      ticks_q <= '0;
      armed_q <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
      drive_q <= drive_d;
      ticks_q <= ticks_d;
      armed_q <= armed_d;
    end
  end

  // Result register.
  logic              out_valid_q;
  logic [StateW-1:0] res_state_q;
  logic              res_drive_q;
  logic [FaultW-1:0] res_code_q;
  logic              res_rej_q;
  logic              res_changed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_state_q   <= state_d;
      res_drive_q   <= drive_d;
      res_code_q    <= code;
      res_rej_q     <= rej;
      res_changed_q <= (state_d != state_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign unit_state_o = res_state_q;
  assign coil_drive_o = res_drive_q;
  assign fault_code_o = res_code_q;
  assign rejected_o   = res_rej_q;
  assign changed_o    = res_changed_q;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the contactor feedback supervisor
// Event requests are driven through the valid/ready input channel and every
// result request is compared field by field against an in-bench model of the
// supervisor. A short directed sequence walks the commands and fault codes,
// then random contactor lifecycles and noise run under four idling patterns,
// with start_timeout rewritten between them while the block is quiet.
// ----------------------------------------------------------------------------
module tb_top;
  import cfs_pkg::*;

  localparam int TimerBits  = TimerBitsDefault;
  // Idle cycles with no request accepted on any channel before giving up.
  localparam int StallLimit = 2000;
  // Requests with a real effect per random phase.
  localparam int PhaseItems = 200;

  // Feedback levels beyond on: both count as a broken connection.
  localparam logic [FeedbackW-1:0] FbConnErr = 2'd2;
  localparam logic [FeedbackW-1:0] FbUndef   = 2'd3;
  // Action codes the block ignores.
  localparam logic [ActionW-1:0] ActSpare5 = 3'd5;
  localparam logic [ActionW-1:0] ActSpare7 = 3'd7;

  typedef struct packed {
    logic [StateW-1:0] unit_state;
    logic              coil_drive;
    logic [FaultW-1:0] fault_code;
    logic              rejected;
    logic              changed;
  } outcome_t;

  // Clock, reset and the DUT's ports. Every input starts at a known value.
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [TimeoutW-1:0]  cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [ActionW-1:0]   action     = ActTick;
  logic [FeedbackW-1:0] coil_fb    = FbOff;
  logic [FeedbackW-1:0] contact_fb = FbOff;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [StateW-1:0]    unit_state;
  logic                 coil_drive;
  logic [FaultW-1:0]    fault_code;
  logic                 rejected;
  logic                 changed;

  // Supervisor model state, mirroring the block's reset values.
  logic [StateW-1:0]    sup_state   = StNotInit;
  logic                 sup_drive   = 1'b0;
  logic [TimerBits-1:0] sup_ticks   = '0;
  logic                 sup_armed   = 1'b0;
  logic [TimeoutW-1:0]  sup_timeout = StartTimeoutReset;

  // Outcomes predicted for accepted event requests, oldest first.
  outcome_t outcome_q[$];

  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sent_items     = 0;
  int unsigned acted_items    = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned cfg_writes     = 0;
  int unsigned idle_cycles    = 0;
  logic [7:0]  state_mask     = '0;
  logic [15:0] fault_mask     = '0;

  contactor_feedback_supervisor_top #(
    .TIMER_BITS(TimerBits)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .action_i          (action),
    .coil_feedback_i   (coil_fb),
    .contact_feedback_i(contact_fb),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .unit_state_o      (unit_state),
    .coil_drive_o      (coil_drive),
    .fault_code_o      (fault_code),
    .rejected_o        (rejected),
    .changed_o         (changed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Supervisor model
  // ---------------------------------------------------------------------------

  // Judges the feedback against the present state and returns the fault code.
  // A tick before init does nothing; a broken connection on either input wins
  // over every other check. In the off state both checks run and the contact
  // check, coming second, overwrites the coil code when both fail.
  function automatic logic [FaultW-1:0] check_feedback(logic [FeedbackW-1:0] coil,
                                                       logic [FeedbackW-1:0] contact);
    logic [FaultW-1:0] code;
    code = FaultNone;
    if (sup_state == StNotInit) return FaultNone;
    if (coil > FbOn || contact > FbOn) begin
      sup_state = StLost;
      return FaultNone;
    end
    case (sup_state)
      StOff: begin
        if (coil != FbOff) code = FaultOffCoil;
        if (contact != FbOff) code = FaultOffContact;
      end
      StOn: begin
        if (coil != FbOn) code = FaultOnCoil;
        else if (contact != FbOn) code = FaultOnContact;
      end
      StStarting: begin
        // The first tick arms the start timer; later ones count it up,
        // saturating, and finish the start once past the timeout.
        if (!sup_armed) begin
          sup_drive = 1'b1;
          sup_armed = 1'b1;
          sup_ticks = '0;
        end else begin
          if (sup_ticks != '1) sup_ticks = sup_ticks + 1'b1;
          if (sup_ticks > sup_timeout) sup_state = StOn;
        end
        if (coil != FbOn) code = FaultStartCoil;
        else if (contact != FbOn) code = FaultStartContact;
      end
      StStopping: begin
        sup_drive = 1'b0;
        sup_state = StOff;
        if (coil != FbOff) code = FaultStopCoil;
        else if (contact != FbOff) code = FaultStopContact;
      end
      default: begin
      end
    endcase
    if (code != FaultNone) sup_state = StError;
    return code;
  endfunction

  // Applies one event request to the model and returns the result it causes.
  function automatic outcome_t supervise_event(logic [ActionW-1:0] act,
                                               logic [FeedbackW-1:0] coil,
                                               logic [FeedbackW-1:0] contact);
    outcome_t          res;
    logic [StateW-1:0] prior;
    prior = sup_state;
    res   = '0;
    case (act)
      ActTick: begin
        res.fault_code = check_feedback(coil, contact);
      end
      ActOn: begin
        if (sup_state == StOff) begin
          sup_state = StStarting;
          sup_drive = 1'b1;
          sup_armed = 1'b0;
          sup_ticks = '0;
        end else begin
          res.rejected = 1'b1;
        end
      end
      ActOff: begin
        if (sup_state == StOn || sup_state == StStarting) begin
          sup_state = StStopping;
          sup_drive = 1'b0;
          sup_armed = 1'b0;
          sup_ticks = '0;
        end else begin
          res.rejected = 1'b1;
        end
      end
      ActHalt: begin
        sup_drive = 1'b0;
        sup_state = StHalt;
      end
      ActInit: begin
        // Init only forces the state; drive and timer are left as they are.
        sup_state      = StOff;
        res.fault_code = check_feedback(coil, contact);
      end
      default: begin
      end
    endcase
    res.unit_state = sup_state;
    res.coil_drive = sup_drive;
    res.changed    = (sup_state != prior);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Sends one event request. Idle cycles come before it so that valid, once
  // raised, stays high with a stable payload until the handshake.
  task automatic send_event(input logic [ActionW-1:0]   act,
                            input logic [FeedbackW-1:0] coil,
                            input logic [FeedbackW-1:0] contact);
    outcome_t res;
    if (act <= ActInit && !(act == ActTick && sup_state == StNotInit))
      acted_items++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    coil_fb    <= coil;
    contact_fb <= contact;
    do @(posedge clk); while (!in_ready);
    res = supervise_event(act, coil, contact);
    outcome_q.push_back(res);
    state_mask[res.unit_state] = 1'b1;
    fault_mask[res.fault_code] = 1'b1;
    sent_items++;
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // Writes start_timeout. Only called once the block has drained.
  task automatic write_start_timeout(input logic [TimeoutW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    sup_timeout = value;
    cfg_writes++;
  endtask

  // Returns the given level most of the time and now and then any code at all.
  function automatic logic [FeedbackW-1:0] noisy(logic [FeedbackW-1:0] level);
    return ($urandom_range(99) < 2) ? FeedbackW'($urandom_range(3)) : level;
  endfunction

  // A tick whose feedback matches what a healthy contactor shows right now.
  task automatic tick_healthy();
    logic [FeedbackW-1:0] lvl;
    lvl = (sup_state == StStarting || sup_state == StOn) ? FbOn : FbOff;
    send_event(ActTick, noisy(lvl), noisy(lvl));
  endtask

  // One full contactor cycle: init, turn on, tick the start timer (into on
  // when the timeout is short), then turn off (or halt) and let the stop
  // settle. Stray feedback may send it to error or lost; the rest plays out there.
  task automatic run_lifecycle();
    int unsigned n;
    send_event(ActInit, noisy(FbOff), noisy(FbOff));
    repeat ($urandom_range(2)) tick_healthy();
    send_event(ActOn, FeedbackW'($urandom_range(3)), FeedbackW'($urandom_range(3)));
    n = (sup_timeout < 24) ? sup_timeout + 2 : 24;
    n += $urandom_range(3);
    repeat (n) tick_healthy();
    if ($urandom_range(3) == 0)
      send_event(ActHalt, FeedbackW'($urandom_range(3)), FeedbackW'($urandom_range(3)));
    else
      send_event(ActOff, FeedbackW'($urandom_range(3)), FeedbackW'($urandom_range(3)));
    tick_healthy();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Commands around init with the reset timeout of 1000 ticks.
  task automatic test_commands();
    send_event(ActTick, FbConnErr, FbConnErr);  // ignored before init
    send_event(ActSpare7, FbUndef, FbUndef);    // unknown action, ignored
    send_event(ActOn, FbOff, FbOff);            // refused before init
    send_event(ActInit, FbOff, FbOff);
    send_event(ActOff, FbOff, FbOff);           // refused while off
    send_event(ActOn, FbOff, FbOff);
    send_event(ActTick, FbOn, FbOn);            // arms the start timer
    send_event(ActTick, FbOn, FbOn);            // far from 1000 ticks yet
    wait_drained();
    write_start_timeout('0);
  endtask

  // Off, on and stop-contact faults, zero timeout so starting ends on the next count.
  task automatic test_fault_codes();
    send_event(ActTick, FbOn, FbOn);            // count passes zero: on
    send_event(ActTick, FbOff, FbOn);           // coil dropped while on
    send_event(ActInit, FbOn, FbOn);            // both off checks fail
    send_event(ActInit, FbOn, FbOff);           // coil stuck on while off
    send_event(ActInit, FbOff, FbOff);
    send_event(ActOn, FbOff, FbOff);
    send_event(ActTick, FbOn, FbOn);
    send_event(ActTick, FbOn, FbOn);
    send_event(ActTick, FbOn, FbOff);           // contact open while on
    send_event(ActInit, FbOff, FbOff);
    send_event(ActOn, FbOff, FbOff);
    send_event(ActOff, FbOff, FbOff);           // turn off during start
    send_event(ActTick, FbOff, FbOn);           // contact stuck while stopping
    send_event(ActHalt, FbOff, FbOff);
    send_event(ActOn, FbOff, FbOff);            // refused in halt
    send_event(ActTick, FbUndef, FbOff);        // broken connection
    send_event(ActTick, FbOff, FbOff);          // lost connection persists
    send_event(ActSpare5, FbOff, FbOff);        // unknown action, ignored
  endtask

  // Random lifecycles and noise under each idling pattern. The timeout is
  // rewritten between phases, covering both extremes, after a full drain.
  task automatic test_random_traffic();
    int unsigned          target;
    int                   phase;
    logic [ActionW-1:0]   act;
    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: write_start_timeout('1);
        1: write_start_timeout(TimeoutW'($urandom_range(15, 1)));
        2: write_start_timeout('0);
        default: write_start_timeout(TimeoutW'($urandom_range(40)));
      endcase
      case (phase)
        0: begin
          send_idle_pct  = 0;
          sink_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 71;
          sink_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          sink_stall_pct = 71;
        end
        default: begin
          send_idle_pct  = 32;
          sink_stall_pct = 32;
        end
      endcase
      target = acted_items + PhaseItems;
      while (acted_items < target) begin
        if ($urandom_range(99) < 80) begin
          run_lifecycle();
        end else begin
          repeat ($urandom_range(4, 1)) begin
            act = ActionW'($urandom_range(7));
            send_event(act, FeedbackW'($urandom_range(3)), FeedbackW'($urandom_range(3)));
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking, receiver stalls and watchdog
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(string field, int unsigned want_v, int unsigned got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] result %0d: %s expected %0d, got %0d",
               $time, results_seen, field, want_v, got_v);
  endfunction

  // Every accepted result request is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result %0d arrived with nothing outstanding", $time, results_seen);
      end else begin
        want = outcome_q.pop_front();
        if (unit_state !== want.unit_state)
          note_mismatch("unit_state", want.unit_state, unit_state);
        if (coil_drive !== want.coil_drive)
          note_mismatch("coil_drive", want.coil_drive, coil_drive);
        if (fault_code !== want.fault_code)
          note_mismatch("fault_code", want.fault_code, fault_code);
        if (rejected !== want.rejected)
          note_mismatch("rejected", want.rejected, rejected);
        if (changed !== want.changed)
          note_mismatch("changed", want.changed, changed);
      end
    end
  end

  // Receiver back-pressure, decided afresh every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Ends the run if no request moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("[%0t] no request accepted for %0d cycles, %0d results outstanding",
               $time, StallLimit, outcome_q.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_commands();
    test_fault_codes();
    test_random_traffic();

    // Let the last results come home, then keep watching for anything the
    // block sends without being asked.
    wait_drained();
    repeat (4) @(posedge clk);

    $display("tb_top: %0d event requests sent, %0d with effect, %0d results checked, %0d timeout writes",
             sent_items, acted_items, results_seen, cfg_writes);
    $display("tb_top: unit states reached %b, fault codes reported %b, %0d mismatches",
             state_mask, fault_mask[8:0], mismatches);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: contactor_feedback_supervisor_top.f
rtl/cfs_pkg.sv
rtl/contactor_feedback_supervisor_top.sv
tb/sv/tb_top.sv
